[rtl/tlik_pkg.sv]
// tlik_pkg: shared constants, types and the arctangent table of the two-link arm
// inverse kinematics solver. No dependencies; every other rtl file imports it.
`default_nettype none

package tlik_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int CQ            = 30;
    localparam int FIELD_W       = 20;
    localparam int LEN_W         = 19;
    localparam int TOL_W         = 16;
    localparam int LIM_W         = 8;
    localparam int CFG_W         = 19;
    localparam int CIX_W         = 2;

    localparam int ANG_W  = 36;
    localparam int XY_W   = 34;
    localparam int CSH    = CQ - FRAC_BITS;
    localparam int SC_W   = XY_W - CSH;
    localparam int CIDX_W = $clog2(CORDIC_STAGES);

    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 48;
    localparam int SQ_W   = 51;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]  CROUND      = XY_W'(1) <<< (CSH - 1);

    localparam logic [NUM_W-1:0] STEP_CLAMP = NUM_W'(1) << 24;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_SINGULAR  = 2'd2;

    localparam logic [CIX_W-1:0] CFG_LINK_ONE  = 2'd0;
    localparam logic [CIX_W-1:0] CFG_LINK_TWO  = 2'd1;
    localparam logic [CIX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CIX_W-1:0] CFG_ITER_LIM  = 2'd3;

    typedef struct packed {
        logic                   done;
        logic signed [SC_W-1:0] sin_v;
        logic signed [SC_W-1:0] cos_v;
    } t_sincos;

    typedef struct packed {
        logic                    done;
        logic signed [MUL_W-1:0] quot;
    } t_div_res;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837830;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388438;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097150;
            5'd10: v = 36'sd1048576;
            5'd11: v = 36'sd524288;
            5'd12: v = 36'sd262144;
            5'd13: v = 36'sd131072;
            5'd14: v = 36'sd65536;
            5'd15: v = 36'sd32768;
            5'd16: v = 36'sd16384;
            5'd17: v = 36'sd8192;
            5'd18: v = 36'sd4096;
            5'd19: v = 36'sd2048;
            5'd20: v = 36'sd1024;
            5'd21: v = 36'sd512;
            5'd22: v = 36'sd256;
            5'd23: v = 36'sd128;
            5'd24: v = 36'sd64;
            5'd25: v = 36'sd32;
            5'd26: v = 36'sd16;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/tlik_mul.sv]
// tlik_mul: shared signed multiplier with a registered product.
// Depends on tlik_pkg.
`default_nettype none

module tlik_mul import tlik_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[rtl/tlik_cordic.sv]
// tlik_cordic: iterative sine/cosine, one rotation per cycle, with angle
// range reduction in front. Depends on tlik_pkg.
`default_nettype none

module tlik_cordic import tlik_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [FIELD_W:0] i_angle,
    output t_sincos                o_res
);

    typedef enum logic [2:0] {
        C_IDLE, C_REDUCE, C_WRAP, C_FOLD, C_ROTATE, C_FINISH
    } t_cstate;

    t_cstate                 r_state;
    logic signed [ANG_W-1:0] r_a;
    logic signed [XY_W-1:0]  r_x, r_y;
    logic                    r_neg;
    logic [CIDX_W-1:0]       r_idx;
    t_sincos                 r_res;

    logic signed [XY_W-1:0]  x_sh, y_sh, x_fin, y_fin, x_rnd, y_rnd;
    logic signed [ANG_W-1:0] atan_v;

    assign x_sh   = r_x >>> r_idx;
    assign y_sh   = r_y >>> r_idx;
    assign atan_v = atan_q30(5'(r_idx));
    assign x_fin  = r_neg ? -r_x : r_x;
    assign y_fin  = r_neg ? -r_y : r_y;
    assign x_rnd  = x_fin + CROUND;
    assign y_rnd  = y_fin + CROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= C_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_a     <= ANG_W'(i_angle) <<< CSH;
                        r_neg   <= 1'b0;
                        r_state <= C_REDUCE;
                    end
                end
                // strip whole turns, truncating toward zero
                C_REDUCE: begin
                    if (r_a >= TWO_PI_Q30) begin
                        r_a <= r_a - TWO_PI_Q30;
                    end else if (r_a <= -TWO_PI_Q30) begin
                        r_a <= r_a + TWO_PI_Q30;
                    end else begin
                        r_state <= C_WRAP;
                    end
                end
                C_WRAP: begin
                    if (r_a > PI_Q30) begin
                        r_a <= r_a - TWO_PI_Q30;
                    end else if (r_a < -PI_Q30) begin
                        r_a <= r_a + TWO_PI_Q30;
                    end
                    r_state <= C_FOLD;
                end
                // fold into the right half plane, negate the outputs later
                C_FOLD: begin
                    if (r_a > HALF_PI_Q30) begin
                        r_a   <= r_a - PI_Q30;
                        r_neg <= 1'b1;
                    end else if (r_a < -HALF_PI_Q30) begin
                        r_a   <= r_a + PI_Q30;
                        r_neg <= 1'b1;
                    end
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_idx   <= '0;
                    r_state <= C_ROTATE;
                end
                C_ROTATE: begin
                    if (r_a >= 0) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_a <= r_a - atan_v;
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_a <= r_a + atan_v;
                    end
                    if (r_idx == CIDX_W'(CORDIC_STAGES - 1)) begin
                        r_state <= C_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                C_FINISH: begin
                    r_res.sin_v <= y_rnd[XY_W-1:CSH];
                    r_res.cos_v <= x_rnd[XY_W-1:CSH];
                    r_res.done  <= 1'b1;
                    r_state     <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/tlik_div.sv]
// tlik_div: restoring signed divider, one quotient bit per cycle, truncating
// toward zero and clamping the quotient magnitude. Depends on tlik_pkg.
`default_nettype none

module tlik_div import tlik_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [MUL_W-1:0] i_den,
    output t_div_res                o_res
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {D_IDLE, D_STEP, D_FINISH} t_dstate;

    t_dstate            r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_quo;
    logic [MUL_W-2:0]   r_rem;
    logic [MUL_W-2:0]   r_den;
    logic               r_neg;
    t_div_res           r_res;

    logic signed [NUM_W-1:0] num_abs;
    logic signed [MUL_W-1:0] den_abs;
    logic [MUL_W-1:0]        trial, trial_sub;
    logic                    ge;
    logic [MUL_W-1:0]        mag;

    assign num_abs   = i_num[NUM_W-1] ? -i_num : i_num;
    assign den_abs   = i_den[MUL_W-1] ? -i_den : i_den;
    assign trial     = {r_rem, r_quo[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign ge        = trial >= {1'b0, r_den};
    assign mag       = (r_quo > STEP_CLAMP) ? MUL_W'(STEP_CLAMP) : r_quo[MUL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= D_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_quo   <= num_abs;
                        r_den   <= den_abs[MUL_W-2:0];
                        r_rem   <= '0;
                        r_neg   <= i_num[NUM_W-1] ^ i_den[MUL_W-1];
                        r_cnt   <= '0;
                        r_state <= D_STEP;
                    end
                end
                D_STEP: begin
                    r_rem <= ge ? trial_sub[MUL_W-2:0] : trial[MUL_W-2:0];
                    r_quo <= {r_quo[NUM_W-2:0], ge};
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= D_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                D_FINISH: begin
                    r_res.quot <= r_neg ? -$signed(mag) : $signed(mag);
                    r_res.done <= 1'b1;
                    r_state    <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/two_link_ik_newton_solver.sv]
// two_link_ik_newton_solver: top level, Newton sequencer around the shared
// multiplier, sine/cosine unit and divider. Depends on tlik_pkg, tlik_mul,
// tlik_cordic and tlik_div.
//
// Usage: an item (target point and two start angles) transfers on the input
// channel when i_valid is high and o_stall is low. The block then holds
// o_stall high while it iterates and takes one item at a time. The result
// (two angles, iteration count, status) sits in an output register with
// o_valid high until the receiver takes it with i_stall low; while the
// receiver stalls the result holds and a new item can already be taken.
// Configuration writes transfer on i_cfg_valid (o_cfg_ready is always high)
// and must be made while the block is idle; the block does not enforce this.
// Each Newton iteration makes three passes of the one-rotation-per-cycle
// sine/cosine unit, two quotients of the bit-serial divider and the work
// on the shared multiplier and the checks; an item runs one iteration after
// another and ends with a write into the output register.
// Reset is synchronous and active low; it empties the output register,
// returns the sequencer to idle and loads the register defaults.
`default_nettype none

module two_link_ik_newton_solver import tlik_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [FIELD_W-1:0] i_target_x,
    input  logic signed [FIELD_W-1:0] i_target_y,
    input  logic signed [FIELD_W-1:0] i_start_angle_one,
    input  logic signed [FIELD_W-1:0] i_start_angle_two,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [FIELD_W-1:0] o_angle_one,
    output logic signed [FIELD_W-1:0] o_angle_two,
    output logic [LIM_W-1:0]          o_iterations_used,
    output logic [1:0]                o_solve_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CIX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SC1, S_SC12, S_SC2,
        S_M_LL, S_M_DET, S_M_A1, S_M_B1, S_M_A2, S_M_B2, S_SUM, S_RES,
        S_N0, S_N1, S_N2, S_N3, S_N4, S_DIV1, S_DIV2,
        S_UPD, S_Q1, S_Q2, S_Q3, S_OUT
    } t_state;

    localparam logic signed [MUL_W:0] P_MAX = (MUL_W+1)'((1 <<< (FIELD_W - 1)) - 1);
    localparam logic signed [MUL_W:0] P_MIN = -((MUL_W+1)'(1 <<< (FIELD_W - 1)));

    t_state r_state;

    logic [LEN_W-1:0] r_len1, r_len2;
    logic [TOL_W-1:0] r_tol;
    logic [LIM_W-1:0] r_lim;

    logic signed [FIELD_W-1:0] r_tx, r_ty, r_p1, r_p2;
    logic [LIM_W-1:0]          r_it;
    logic [1:0]                r_status;
    logic signed [SC_W-1:0]    r_s1, r_c1, r_s12, r_c12, r_s2;
    logic signed [MUL_W-1:0]   r_det, r_a1, r_b1, r_a2, r_b2;
    logic signed [MUL_W-1:0]   r_sx, r_sy, r_r1, r_r2, r_d1, r_d2;
    logic signed [SQ_W-1:0]    r_acc, r_sq;
    logic signed [NUM_W-1:0]   r_num1, r_num2;

    logic                      r_out_valid;
    logic signed [FIELD_W-1:0] r_out_a1, r_out_a2;
    logic [LIM_W-1:0]          r_out_it;
    logic [1:0]                r_out_st;

    logic signed [MUL_W-1:0]  mul_a, mul_b, len1_op, len2_op, tol_op, prod_q;
    logic signed [PROD_W-1:0] prod;
    logic signed [SQ_W-1:0]   prod_w;
    logic                     sc_start, div_start;
    logic signed [FIELD_W:0]  sc_angle;
    logic signed [NUM_W-1:0]  div_num;
    t_sincos                  sc_res;
    t_div_res                 div_res;
    logic signed [MUL_W:0]    p1_new, p2_new;
    logic                     out_free;

    assign len1_op = {{(MUL_W-LEN_W){1'b0}}, r_len1};
    assign len2_op = {{(MUL_W-LEN_W){1'b0}}, r_len2};
    assign tol_op  = {{(MUL_W-TOL_W){1'b0}}, r_tol} + MUL_W'(1);
    assign prod_q  = prod[FRAC_BITS+MUL_W-1:FRAC_BITS];
    assign prod_w  = prod[SQ_W-1:0];
    assign p1_new  = (MUL_W+1)'(r_p1) - (MUL_W+1)'(r_d1);
    assign p2_new  = (MUL_W+1)'(r_p2) - (MUL_W+1)'(r_d2);
    assign out_free = !r_out_valid || !i_stall;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M_LL:  begin mul_a = len1_op; mul_b = len2_op;       end
            S_M_DET: begin mul_a = prod_q;  mul_b = MUL_W'(r_s2);  end
            S_M_A1:  begin mul_a = len1_op; mul_b = MUL_W'(r_s1);  end
            S_M_B1:  begin mul_a = len2_op; mul_b = MUL_W'(r_s12); end
            S_M_A2:  begin mul_a = len1_op; mul_b = MUL_W'(r_c1);  end
            S_M_B2:  begin mul_a = len2_op; mul_b = MUL_W'(r_c12); end
            S_N0:    begin mul_a = r_b2;    mul_b = r_r1;          end
            S_N1:    begin mul_a = r_b1;    mul_b = r_r2;          end
            S_N2:    begin mul_a = r_sy;    mul_b = r_r2;          end
            S_N3:    begin mul_a = r_sx;    mul_b = r_r1;          end
            S_UPD:   begin mul_a = r_d1;    mul_b = r_d1;          end
            S_Q1:    begin mul_a = r_d2;    mul_b = r_d2;          end
            S_Q2:    begin mul_a = tol_op;  mul_b = tol_op;        end
            default: begin mul_a = '0;      mul_b = '0;            end
        endcase
    end

    always_comb begin
        sc_start = 1'b0;
        sc_angle = (FIELD_W+1)'(r_p1);
        case (r_state)
            S_CHECK: sc_start = r_it < r_lim;
            S_SC1: begin
                sc_start = sc_res.done;
                sc_angle = (FIELD_W+1)'(r_p1) + (FIELD_W+1)'(r_p2);
            end
            S_SC12: begin
                sc_start = sc_res.done;
                sc_angle = (FIELD_W+1)'(r_p2);
            end
            default: sc_start = 1'b0;
        endcase
    end

    assign div_start = (r_state == S_N4) || (r_state == S_DIV1 && div_res.done);
    assign div_num   = (r_state == S_N4) ? r_num1 : r_num2;

    tlik_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    tlik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sc_start),
        .i_angle (sc_angle),
        .o_res   (sc_res)
    );

    tlik_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len1      <= LEN_W'(1 << FRAC_BITS);
            r_len2      <= LEN_W'(1 << FRAC_BITS);
            r_tol       <= TOL_W'(7);
            r_lim       <= LIM_W'(64);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LINK_ONE:  r_len1 <= i_cfg_data[LEN_W-1:0];
                    CFG_LINK_TWO:  r_len2 <= i_cfg_data[LEN_W-1:0];
                    CFG_TOLERANCE: r_tol  <= i_cfg_data[TOL_W-1:0];
                    CFG_ITER_LIM:  r_lim  <= i_cfg_data[LIM_W-1:0];
                    default:       r_lim  <= r_lim;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_out_a1    <= r_p1;
                r_out_a2    <= r_p2;
                r_out_it    <= r_it;
                r_out_st    <= r_status;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tx    <= i_target_x;
                        r_ty    <= i_target_y;
                        r_p1    <= i_start_angle_one;
                        r_p2    <= i_start_angle_two;
                        r_it    <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_it < r_lim) begin
                        r_state <= S_SC1;
                    end else begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_OUT;
                    end
                end
                S_SC1: begin
                    if (sc_res.done) begin
                        r_s1    <= sc_res.sin_v;
                        r_c1    <= sc_res.cos_v;
                        r_state <= S_SC12;
                    end
                end
                S_SC12: begin
                    if (sc_res.done) begin
                        r_s12   <= sc_res.sin_v;
                        r_c12   <= sc_res.cos_v;
                        r_state <= S_SC2;
                    end
                end
                S_SC2: begin
                    if (sc_res.done) begin
                        r_s2    <= sc_res.sin_v;
                        r_state <= S_M_LL;
                    end
                end
                S_M_LL:  r_state <= S_M_DET;
                S_M_DET: r_state <= S_M_A1;
                S_M_A1: begin
                    r_det <= prod_q;
                    if (prod_q == '0) begin
                        r_status <= ST_SINGULAR;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_M_B1;
                    end
                end
                S_M_B1: begin
                    r_a1    <= prod_q;
                    r_state <= S_M_A2;
                end
                S_M_A2: begin
                    r_b1    <= prod_q;
                    r_state <= S_M_B2;
                end
                S_M_B2: begin
                    r_a2    <= prod_q;
                    r_state <= S_SUM;
                end
                // tip position sums, the residual follows
                S_SUM: begin
                    r_b2    <= prod_q;
                    r_sx    <= r_a2 + prod_q;
                    r_sy    <= r_a1 + r_b1;
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_r1    <= r_sx - MUL_W'(r_tx);
                    r_r2    <= r_sy - MUL_W'(r_ty);
                    r_state <= S_N0;
                end
                S_N0: r_state <= S_N1;
                S_N1: begin
                    r_acc   <= prod_w;
                    r_state <= S_N2;
                end
                S_N2: begin
                    r_num1  <= NUM_W'(r_acc + prod_w);
                    r_state <= S_N3;
                end
                S_N3: begin
                    r_acc   <= prod_w;
                    r_state <= S_N4;
                end
                S_N4: begin
                    r_num2  <= NUM_W'(-r_acc - prod_w);
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_res.done) begin
                        r_d1    <= div_res.quot;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_res.done) begin
                        r_d2    <= div_res.quot;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (p1_new > P_MAX) begin
                        r_p1 <= P_MAX[FIELD_W-1:0];
                    end else if (p1_new < P_MIN) begin
                        r_p1 <= P_MIN[FIELD_W-1:0];
                    end else begin
                        r_p1 <= p1_new[FIELD_W-1:0];
                    end
                    if (p2_new > P_MAX) begin
                        r_p2 <= P_MAX[FIELD_W-1:0];
                    end else if (p2_new < P_MIN) begin
                        r_p2 <= P_MIN[FIELD_W-1:0];
                    end else begin
                        r_p2 <= p2_new[FIELD_W-1:0];
                    end
                    r_it    <= r_it + 1'b1;
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    r_acc   <= prod_w;
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_sq    <= r_acc + prod_w;
                    r_state <= S_Q3;
                end
                // floor sqrt of the squared step is within tolerance
                // exactly when the square is below (tol + 1) squared
                S_Q3: begin
                    if (r_sq < prod_w) begin
                        r_status <= ST_CONVERGED;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall           = r_state != S_IDLE;
    assign o_valid           = r_out_valid;
    assign o_angle_one       = r_out_a1;
    assign o_angle_two       = r_out_a2;
    assign o_iterations_used = r_out_it;
    assign o_solve_status    = r_out_st;
    assign o_cfg_ready       = 1'b1;

endmodule

`default_nettype wire

[rtl/tlik_check.sv]
// tlik_check: port-level checks on the two-link arm solver, attached to the
// top level by the bind below. Depends on tlik_pkg.
`default_nettype none

module tlik_check import tlik_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [FIELD_W-1:0] o_angle_one,
    input logic [LIM_W-1:0]          o_iterations_used,
    input logic [1:0]                o_solve_status
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle_one))
        else $error("result dropped or changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // convergence is only decided after at least one update
    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_solve_status == ST_CONVERGED |-> o_iterations_used != '0)
        else $error("converged with no iteration");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after input transfer");

endmodule

bind two_link_ik_newton_solver tlik_check u_tlik_check (.*);

`default_nettype wire
